/* src/i2cms_pkg.sv */
// Shared types and constants for the I2C master status sequencer.
// Depends on nothing; imported by i2cms_decode and i2c_master_status_sequencer.
`default_nettype none

package i2cms_pkg;

    // Kinds of input beat
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_EVENT = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_BEGIN = 2'd3;

    // Controller status codes
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_REP_START   = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST    = 8'h38;
    localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
    localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

    // Configuration register indexes
    localparam logic [1:0] CFG_WRITE_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_READ_LENGTH    = 2'd1;
    localparam logic [1:0] CFG_RESTART_SECOND = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_STARTED   = 3'd1,
        PH_RESTARTED = 3'd2,
        PH_REPSTART  = 3'd3,
        PH_DACK      = 3'd4,
        PH_DNACK     = 3'd5
    } phase_t;

    // Decoded actions of one beat
    typedef struct packed {
        logic   buf_write;
        logic   read_back;
        logic   send_valid;
        logic   set_start;
        logic   set_stop;
        logic   set_ack;
        logic   clear_start;
        logic   clear_interrupt;
        phase_t phase;
    } seq_ctrl_t;

endpackage

`default_nettype wire

/* src/i2c_master_status_sequencer.sv */
// Top level of the I2C master status sequencer: stream ports, state, buffer memory.
// Depends on i2cms_pkg and i2cms_decode.
`default_nettype none

// Steps an I2C master transfer from controller status codes. Each input beat
// (load, status event, read-back or begin) yields exactly one result beat in the
// cycle after it is accepted; a new beat is accepted in every cycle while the
// result side keeps up, so throughput is one item per cycle. All positions,
// phase and control actions are settled at acceptance; the simple dual-port
// transfer buffer (BUFFER_DEPTH bytes, one write and one registered read per
// cycle) supplies send_byte and buffer_byte in the result register. Buffer
// entries are undefined until loaded. Configuration writes are always ready
// and should be issued only while no beat is in flight.
module i2c_master_status_sequencer #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // status_code[7:0], data_byte[15:8],
                                        // buffer_index[21:16], zero[23:22]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // send_valid[0], send_byte[8:1], set_start[9],
                                        // set_stop[10], set_ack[11], clear_start[12],
                                        // clear_interrupt[13], master_state[16:14],
                                        // buffer_byte[24:17], zero[31:25]
    // Configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [5:0]  cfg_data
);

    import i2cms_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [5:0]    write_length_reg;
    logic [5:0]    read_length_reg;
    logic          restart_second_reg;

    logic [AW-1:0] write_pos_reg;
    logic [AW-1:0] read_pos_reg;
    phase_t        phase_reg;
    logic          out_valid_reg;
    seq_ctrl_t     ctl_reg;
    logic [7:0]    rdata_reg;

    logic [7:0]    buf_mem [BUFFER_DEPTH];

    seq_ctrl_t     ctl_next;
    logic [AW-1:0] write_pos_next;
    logic [AW-1:0] read_pos_next;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          accept;
    logic [7:0]    send_byte;
    logic [7:0]    buffer_byte;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    i2cms_decode #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_decode (
        .action         (s_tuser),
        .status_code    (s_tdata[7:0]),
        .buffer_index   (s_tdata[21:16]),
        .phase          (phase_reg),
        .write_pos      (write_pos_reg),
        .read_pos       (read_pos_reg),
        .write_length   (write_length_reg),
        .read_length    (read_length_reg),
        .restart_second (restart_second_reg),
        .ctl            (ctl_next),
        .write_pos_next (write_pos_next),
        .read_pos_next  (read_pos_next),
        .rd_addr        (rd_addr),
        .wr_addr        (wr_addr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_length_reg   <= '0;
            read_length_reg    <= '0;
            restart_second_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WRITE_LENGTH:   write_length_reg   <= cfg_data;
                CFG_READ_LENGTH:    read_length_reg    <= cfg_data;
                CFG_RESTART_SECOND: restart_second_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg <= '0;
            read_pos_reg  <= '0;
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                write_pos_reg <= write_pos_next;
                read_pos_reg  <= read_pos_next;
                phase_reg     <= ctl_next.phase;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload; hold while the result side stalls
    always_ff @(posedge clk)
    begin
        if (accept)
            ctl_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && ctl_next.buf_write)
            buf_mem[wr_addr] <= s_tdata[15:8];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rdata_reg <= buf_mem[rd_addr];
    end

    assign send_byte   = ctl_reg.send_valid ? rdata_reg : 8'h00;
    assign buffer_byte = ctl_reg.read_back ? rdata_reg : 8'h00;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       buffer_byte,
                       ctl_reg.phase,
                       ctl_reg.clear_interrupt,
                       ctl_reg.clear_start,
                       ctl_reg.set_ack,
                       ctl_reg.set_stop,
                       ctl_reg.set_start,
                       send_byte,
                       ctl_reg.send_valid};

endmodule

`default_nettype wire

/* src/i2cms_decode.sv */
// Combinational decode of one beat: control actions, next positions and buffer addresses.
// Depends on i2cms_pkg.
`default_nettype none

module i2cms_decode #(
    parameter int BUFFER_DEPTH = 64,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  wire logic [1:0]        action,
    input  wire logic [7:0]        status_code,
    input  wire logic [5:0]        buffer_index,
    input  wire i2cms_pkg::phase_t phase,
    input  wire logic [AW-1:0]     write_pos,
    input  wire logic [AW-1:0]     read_pos,
    input  wire logic [5:0]        write_length,
    input  wire logic [5:0]        read_length,
    input  wire logic              restart_second,
    output i2cms_pkg::seq_ctrl_t   ctl,
    output logic [AW-1:0]          write_pos_next,
    output logic [AW-1:0]          read_pos_next,
    output logic [AW-1:0]          rd_addr,
    output logic [AW-1:0]          wr_addr
);

    import i2cms_pkg::*;

    localparam int CW = (AW > 6) ? AW : 6;
    localparam int DW = CW + 1;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(BUFFER_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    function automatic logic [AW-1:0] wrap_add3(input logic [AW-1:0] p);
        logic [AW:0] s;
        s = {1'b0, p} + (AW+1)'(3);
        if (s >= (AW+1)'(BUFFER_DEPTH))
            s = s - (AW+1)'(BUFFER_DEPTH);
        return s[AW-1:0];
    endfunction

    // Index below 64 and depth at least 8: seven conditional subtracts suffice
    function automatic logic [AW-1:0] wrap_index(input logic [5:0] idx);
        logic [DW-1:0] v;
        v = DW'(idx);
        for (int k = 0; k < 7; k++)
        begin
            if (v >= DW'(BUFFER_DEPTH))
                v = v - DW'(BUFFER_DEPTH);
        end
        return v[AW-1:0];
    endfunction

    logic [AW-1:0] write_inc;
    logic [AW-1:0] read_inc;
    logic [AW-1:0] index_wrapped;
    logic          write_done;
    logic          write_inc_done;
    logic          read_inc_done;
    logic          reads_left;

    assign write_inc      = wrap_inc(write_pos);
    assign read_inc       = wrap_inc(read_pos);
    assign index_wrapped  = wrap_index(buffer_index);
    assign write_done     = (CW'(write_pos) == CW'(write_length));
    assign write_inc_done = (CW'(write_inc) == CW'(write_length));
    assign read_inc_done  = (CW'(read_inc) == CW'(read_length));
    assign reads_left     = (read_length != 6'd0);

    always_comb
    begin
        ctl            = '0;
        ctl.phase      = phase;
        write_pos_next = write_pos;
        read_pos_next  = read_pos;
        rd_addr        = index_wrapped;
        wr_addr        = index_wrapped;

        case (action)
            ACT_LOAD:
            begin
                ctl.buf_write = 1'b1;
            end
            ACT_READ:
            begin
                ctl.read_back = 1'b1;
            end
            ACT_BEGIN:
            begin
                write_pos_next = '0;
                read_pos_next  = '0;
                ctl.phase      = PH_IDLE;
                ctl.set_start  = 1'b1;
            end
            ACT_EVENT:
            begin
                ctl.clear_interrupt = 1'b1;
                case (status_code)
                    ST_START:
                    begin
                        ctl.send_valid  = 1'b1;
                        rd_addr         = '0;
                        ctl.clear_start = 1'b1;
                        ctl.phase       = PH_STARTED;
                    end
                    ST_REP_START:
                    begin
                        ctl.send_valid  = restart_second;
                        rd_addr         = AW'(2);
                        ctl.clear_start = 1'b1;
                        ctl.phase       = PH_RESTARTED;
                    end
                    ST_SLA_W_ACK:
                    begin
                        if (phase == PH_STARTED)
                        begin
                            ctl.send_valid = 1'b1;
                            rd_addr        = write_inc;
                            write_pos_next = write_inc;
                            ctl.phase      = PH_DACK;
                        end
                    end
                    ST_DATA_W_ACK, ST_DATA_W_NACK:
                    begin
                        if (!write_done)
                        begin
                            ctl.send_valid = 1'b1;
                            rd_addr        = write_inc;
                            write_pos_next = write_inc;
                            if (!write_inc_done)
                                ctl.phase = PH_DACK;
                            else if (reads_left)
                            begin
                                ctl.set_start = 1'b1;
                                ctl.phase     = PH_REPSTART;
                            end
                            else
                                ctl.phase = PH_DNACK;
                        end
                        else if (reads_left)
                        begin
                            ctl.set_start = 1'b1;
                            ctl.phase     = PH_REPSTART;
                        end
                        else
                        begin
                            ctl.set_stop = 1'b1;
                            ctl.phase    = PH_DNACK;
                        end
                    end
                    ST_SLA_R_ACK:
                    begin
                        ctl.set_ack = 1'b1;
                    end
                    ST_DATA_R_ACK, ST_DATA_R_NACK:
                    begin
                        // Store the received byte three entries past the read position
                        ctl.buf_write = 1'b1;
                        wr_addr       = wrap_add3(read_pos);
                        ctl.set_ack   = 1'b1;
                        if (!read_inc_done)
                        begin
                            read_pos_next = read_inc;
                            ctl.phase     = PH_DACK;
                        end
                        else
                        begin
                            read_pos_next = '0;
                            ctl.phase     = PH_DNACK;
                        end
                    end
                    ST_SLA_W_NACK, ST_SLA_R_NACK:
                    begin
                        ctl.phase = PH_DNACK;
                    end
                    ST_ARB_LOST:
                    begin
                        // hold the phase; only the interrupt is cleared
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
